>>> hw/rtl/rqnt_pkg.sv
// ----------------------------------------------------------------------------
// rqnt_pkg
// Shared types and constants of the int32 to int8 requantizer.
// ----------------------------------------------------------------------------
`default_nettype none

package rqnt_pkg;

  // Lane count and field widths fixed by the beat format
  localparam int unsigned LANES   = 8;
  localparam int unsigned VAL_W   = 32;
  localparam int unsigned CNT_W   = 4;
  localparam int unsigned RATIO_W = 48;
  localparam int unsigned ABS_W   = 31;
  localparam int unsigned BYTE_W  = 8;

  // Q8.40 constants: 1.0 and 127.0
  localparam logic [RATIO_W-1:0] RATIO_ONE = 48'h01_0000_0000_00;
  localparam logic [RATIO_W-1:0] RATIO_NUM = 48'h7F_0000_0000_00;

  // Output queue
  localparam int unsigned OQ_DEPTH = 8;
  localparam int unsigned OQ_AW    = 3;

  // Configuration register indexes
  typedef enum logic [1:0] {
    CFG_DYNAMIC_MODE    = 2'd0,
    CFG_FIXED_RATIO     = 2'd1,
    CFG_UNSIGNED_OUTPUT = 2'd2
  } cfg_idx_e;

  // Control sequencer states
  typedef enum logic [2:0] {
    S_IDLE,
    S_FOLD,
    S_DSTART,
    S_DWAIT,
    S_DRAIN
  } rqnt_state_e;

  typedef struct packed {
    logic signed [VAL_W-1:0] lane0_value;
    logic signed [VAL_W-1:0] lane1_value;
    logic signed [VAL_W-1:0] lane2_value;
    logic signed [VAL_W-1:0] lane3_value;
    logic signed [VAL_W-1:0] lane4_value;
    logic signed [VAL_W-1:0] lane5_value;
    logic signed [VAL_W-1:0] lane6_value;
    logic signed [VAL_W-1:0] lane7_value;
    logic [CNT_W-1:0]        valid_lanes;
    logic                    tensor_end;
  } in_beat_t;

  typedef struct packed {
    logic [BYTE_W-1:0]  lane0_byte;
    logic [BYTE_W-1:0]  lane1_byte;
    logic [BYTE_W-1:0]  lane2_byte;
    logic [BYTE_W-1:0]  lane3_byte;
    logic [BYTE_W-1:0]  lane4_byte;
    logic [BYTE_W-1:0]  lane5_byte;
    logic [BYTE_W-1:0]  lane6_byte;
    logic [BYTE_W-1:0]  lane7_byte;
    logic [CNT_W-1:0]   out_valid_lanes;
    logic               run_end;
    logic [RATIO_W-1:0] ratio_used;
  } out_beat_t;

  // Per-lane control
  typedef struct packed {
    logic lane_en;
    logic unsigned_out;
  } lane_ctl_t;

endpackage

`default_nettype wire

>>> hw/rtl/int32_to_int8_requantizer_top.sv
// Fixed mode: a group is taken each cycle unless in_stall_o is high; its result beat
// passes the lane product and byte registers and the output queue before it is valid.
// Dynamic mode: groups load one per cycle while idle; the last group triggers a max fold
// and a bit-serial divide; the buffer then drains one result per cycle while credit_ok holds.
// The 8-entry output queue and the 3-stage read/multiply pipeline set the rate.
// Reset (async, active low) clears control state; buffer contents are not cleared.
// ----------------------------------------------------------------------------
// int32_to_int8_requantizer_top
// Requantizes groups of signed 32-bit accumulators to bytes with a fixed or
// data-derived Q8.40 ratio.
// ----------------------------------------------------------------------------
`default_nettype none

module int32_to_int8_requantizer_top #(
  parameter int unsigned BUFFER_GROUPS = 64
) (
  input  wire logic                               clk_i,
  input  wire logic                               rst_ni,
  input  wire logic                               in_valid_i,
  output      logic                               in_stall_o,
  input  wire rqnt_pkg::in_beat_t                 in_beat_i,
  output      logic                               out_valid_o,
  input  wire logic                               out_stall_i,
  output      rqnt_pkg::out_beat_t                out_beat_o,
  input  wire logic                               cfg_we_i,
  input  wire logic [1:0]                         cfg_idx_i,
  input  wire logic [rqnt_pkg::RATIO_W-1:0]       cfg_wdata_i
);

  localparam int unsigned L     = rqnt_pkg::LANES;
  localparam int unsigned VW    = rqnt_pkg::VAL_W;
  localparam int unsigned CW    = rqnt_pkg::CNT_W;
  localparam int unsigned RW    = rqnt_pkg::RATIO_W;
  localparam int unsigned AW    = (BUFFER_GROUPS > 1) ? $clog2(BUFFER_GROUPS) : 1;
  localparam int unsigned HW    = $clog2(BUFFER_GROUPS + 1);
  localparam int unsigned RAM_W = CW + L * VW;
  localparam logic [HW-1:0] BG  = HW'(BUFFER_GROUPS);

  // Configuration registers
  logic          dyn_q;
  logic [RW-1:0] fixed_ratio_q;
  logic          uns_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      dyn_q         <= 1'b0;
      fixed_ratio_q <= '0;
      uns_q         <= 1'b0;
    end else if (cfg_we_i) begin
      case (rqnt_pkg::cfg_idx_e'(cfg_idx_i))
        rqnt_pkg::CFG_DYNAMIC_MODE:    dyn_q         <= cfg_wdata_i[0];
        rqnt_pkg::CFG_FIXED_RATIO:     fixed_ratio_q <= cfg_wdata_i;
        rqnt_pkg::CFG_UNSIGNED_OUTPUT: uns_q         <= cfg_wdata_i[0];
        default: ;
      endcase
    end
  end

  // Input unpacking and lane count saturation
  logic [L-1:0][VW-1:0] in_vals;
  logic [CW-1:0]        in_cnt;

  always_comb begin
    in_vals[0] = in_beat_i.lane0_value;
    in_vals[1] = in_beat_i.lane1_value;
    in_vals[2] = in_beat_i.lane2_value;
    in_vals[3] = in_beat_i.lane3_value;
    in_vals[4] = in_beat_i.lane4_value;
    in_vals[5] = in_beat_i.lane5_value;
    in_vals[6] = in_beat_i.lane6_value;
    in_vals[7] = in_beat_i.lane7_value;
    in_cnt = (in_beat_i.valid_lanes > CW'(L)) ? CW'(L) : in_beat_i.valid_lanes;
  end

  // State
  rqnt_pkg::rqnt_state_e state_q, state_d;
  logic [HW-1:0]                 held_q;
  logic [HW-1:0]                 rd_idx_q;
  logic [rqnt_pkg::ABS_W-1:0]    run_max_q;
  logic [RW-1:0]                 ratio_q;
  logic                          rd_v_q, rd_last_q;
  logic                          v1_q, v2_q;
  logic [CW-1:0]                 s1_cnt_q, s2_cnt_q;
  logic                          s1_last_q, s2_last_q;
  logic [RW-1:0]                 s1_ratio_q, s2_ratio_q;

  // Output queue state
  rqnt_pkg::out_beat_t           oq_mem_q [rqnt_pkg::OQ_DEPTH];
  logic [rqnt_pkg::OQ_AW-1:0]    oq_wr_q, oq_rd_q;
  logic [rqnt_pkg::OQ_AW:0]      oq_cnt_q;
  logic                          oq_push, oq_pop;
  logic [rqnt_pkg::OQ_AW+1:0]    occ;
  logic                          credit_ok;

  // Handshake and issue control
  logic in_acc, fix_issue, dyn_acc, store;
  logic rd_issue, drain_done;
  logic div_start, div_done;
  logic [RW-1:0] div_quot;

  assign occ       = (rqnt_pkg::OQ_AW+2)'(oq_cnt_q) + (rqnt_pkg::OQ_AW+2)'(v1_q)
                   + (rqnt_pkg::OQ_AW+2)'(v2_q) + (rqnt_pkg::OQ_AW+2)'(rd_v_q);
  assign credit_ok = occ < (rqnt_pkg::OQ_AW+2)'(rqnt_pkg::OQ_DEPTH);

  assign in_stall_o = !((state_q == rqnt_pkg::S_IDLE) && !rd_v_q && (dyn_q || credit_ok));
  assign in_acc     = in_valid_i && !in_stall_o;
  assign fix_issue  = in_acc && !dyn_q;
  assign dyn_acc    = in_acc && dyn_q;
  assign store      = dyn_acc && (held_q < BG);
  assign drain_done = (state_q == rqnt_pkg::S_DRAIN) && (rd_idx_q == held_q);
  assign rd_issue   = (state_q == rqnt_pkg::S_DRAIN) && (rd_idx_q != held_q) && credit_ok;

  // Sequencer
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= rqnt_pkg::S_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  always_comb begin
    state_d   = state_q;
    div_start = 1'b0;
    case (state_q)
      rqnt_pkg::S_IDLE: begin
        if (dyn_acc && in_beat_i.tensor_end) begin
          state_d = rqnt_pkg::S_FOLD;
        end
      end
      rqnt_pkg::S_FOLD: begin
        state_d = rqnt_pkg::S_DSTART;
      end
      rqnt_pkg::S_DSTART: begin
        if (run_max_q == '0) begin
          state_d = rqnt_pkg::S_DRAIN;
        end else begin
          div_start = 1'b1;
          state_d   = rqnt_pkg::S_DWAIT;
        end
      end
      rqnt_pkg::S_DWAIT: begin
        if (div_done) begin
          state_d = rqnt_pkg::S_DRAIN;
        end
      end
      rqnt_pkg::S_DRAIN: begin
        if (drain_done) begin
          state_d = rqnt_pkg::S_IDLE;
        end
      end
      default: state_d = rqnt_pkg::S_IDLE;
    endcase
  end

  // Group buffer
  logic [RAM_W-1:0] ram_wdata, ram_rdata;

  assign ram_wdata = {in_cnt, in_vals};

  rqnt_ram #(
    .WIDTH (RAM_W),
    .DEPTH (BUFFER_GROUPS)
  ) u_buf (
    .clk_i   (clk_i),
    .we_i    (store),
    .waddr_i (held_q[AW-1:0]),
    .wdata_i (ram_wdata),
    .re_i    (rd_issue),
    .raddr_i (rd_idx_q[AW-1:0]),
    .rdata_o (ram_rdata)
  );

  // Max tracking
  logic [L-1:0][rqnt_pkg::ABS_W-1:0] lane_abs;
  logic                              fold_v;
  logic [rqnt_pkg::ABS_W-1:0]        fold_max;

  rqnt_maxmerge u_merge (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .valid_i   (store),
    .abs_i     (lane_abs),
    .running_i (run_max_q),
    .fold_o    (fold_v),
    .max_o     (fold_max)
  );

  // Dynamic ratio divider
  rqnt_div u_div (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .start_i    (div_start),
    .dividend_i (rqnt_pkg::RATIO_NUM + RW'(run_max_q >> 1)),
    .divisor_i  (run_max_q),
    .done_o     (div_done),
    .quot_o     (div_quot)
  );

  // Buffer bookkeeping, ratio and drain counters
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      held_q    <= '0;
      run_max_q <= '0;
      rd_idx_q  <= '0;
      rd_v_q    <= 1'b0;
    end else begin
      rd_v_q <= rd_issue;
      if (store) begin
        held_q <= held_q + HW'(1);
      end
      if (fold_v) begin
        run_max_q <= fold_max;
      end
      if (state_q == rqnt_pkg::S_DSTART) begin
        rd_idx_q <= '0;
      end else if (rd_issue) begin
        rd_idx_q <= rd_idx_q + HW'(1);
      end
      if (drain_done) begin
        held_q    <= '0;
        run_max_q <= '0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if ((state_q == rqnt_pkg::S_DSTART) && (run_max_q == '0)) begin
      ratio_q <= rqnt_pkg::RATIO_ONE;
    end else if (div_done) begin
      ratio_q <= div_quot;
    end
    rd_last_q <= (rd_idx_q + HW'(1)) == held_q;
  end

  // Lane issue source: buffer read data while draining, else the input beat
  logic [L-1:0][VW-1:0] iss_vals;
  logic [CW-1:0]        iss_cnt;
  logic                 iss_last;
  logic [RW-1:0]        iss_ratio;
  logic                 iss_v;
  logic [L-1:0][rqnt_pkg::BYTE_W-1:0] lane_byte;

  always_comb begin
    iss_v     = fix_issue || rd_v_q;
    iss_vals  = rd_v_q ? ram_rdata[L*VW-1:0] : in_vals;
    iss_cnt   = rd_v_q ? ram_rdata[RAM_W-1 -: CW] : in_cnt;
    iss_last  = rd_v_q ? rd_last_q : in_beat_i.tensor_end;
    iss_ratio = rd_v_q ? ratio_q : fixed_ratio_q;
  end

  for (genvar g = 0; g < L; g++) begin : g_lane
    rqnt_pkg::lane_ctl_t ctl;
    assign ctl.lane_en      = CW'(g) < iss_cnt;
    assign ctl.unsigned_out = uns_q;

    rqnt_lane u_lane (
      .clk_i   (clk_i),
      .value_i (iss_vals[g]),
      .ctl_i   (ctl),
      .ratio_i (iss_ratio),
      .abs_o   (lane_abs[g]),
      .byte_o  (lane_byte[g])
    );
  end

  // Sideband pipeline matching the lane stages
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v1_q <= 1'b0;
      v2_q <= 1'b0;
    end else begin
      v1_q <= iss_v;
      v2_q <= v1_q;
    end
  end

  always_ff @(posedge clk_i) begin
    s1_cnt_q   <= iss_cnt;
    s1_last_q  <= iss_last;
    s1_ratio_q <= iss_ratio;
    s2_cnt_q   <= s1_cnt_q;
    s2_last_q  <= s1_last_q;
    s2_ratio_q <= s1_ratio_q;
  end

  // Output queue
  rqnt_pkg::out_beat_t res;

  always_comb begin
    res.lane0_byte      = lane_byte[0];
    res.lane1_byte      = lane_byte[1];
    res.lane2_byte      = lane_byte[2];
    res.lane3_byte      = lane_byte[3];
    res.lane4_byte      = lane_byte[4];
    res.lane5_byte      = lane_byte[5];
    res.lane6_byte      = lane_byte[6];
    res.lane7_byte      = lane_byte[7];
    res.out_valid_lanes = s2_cnt_q;
    res.run_end         = s2_last_q;
    res.ratio_used      = s2_ratio_q;
  end

  assign oq_push     = v2_q;
  assign out_valid_o = oq_cnt_q != '0;
  assign oq_pop      = out_valid_o && !out_stall_i;
  assign out_beat_o  = oq_mem_q[oq_rd_q];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      oq_wr_q  <= '0;
      oq_rd_q  <= '0;
      oq_cnt_q <= '0;
    end else begin
      if (oq_push) begin
        oq_wr_q <= oq_wr_q + rqnt_pkg::OQ_AW'(1);
      end
      if (oq_pop) begin
        oq_rd_q <= oq_rd_q + rqnt_pkg::OQ_AW'(1);
      end
      case ({oq_push, oq_pop})
        2'b10:   oq_cnt_q <= oq_cnt_q + (rqnt_pkg::OQ_AW+1)'(1);
        2'b01:   oq_cnt_q <= oq_cnt_q - (rqnt_pkg::OQ_AW+1)'(1);
        default: oq_cnt_q <= oq_cnt_q;
      endcase
    end
  end

  always_ff @(posedge clk_i) begin
    if (oq_push) begin
      oq_mem_q[oq_wr_q] <= res;
    end
  end

  // Checks
  a_oq_no_overflow: assert property (@(posedge clk_i) disable iff (!rst_ni)
    oq_push && !oq_pop |-> oq_cnt_q < (rqnt_pkg::OQ_AW+1)'(rqnt_pkg::OQ_DEPTH))
    else $error("output queue overflow");

  a_issue_no_collision: assert property (@(posedge clk_i) disable iff (!rst_ni)
    rd_v_q |-> !fix_issue)
    else $error("input issue collides with buffer drain");

  a_held_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    held_q <= BG)
    else $error("buffer fill count beyond depth");

  a_div_done_in_wait: assert property (@(posedge clk_i) disable iff (!rst_ni)
    div_done |-> state_q == rqnt_pkg::S_DWAIT)
    else $error("divider finished outside its wait state");

  a_drain_clears: assert property (@(posedge clk_i) disable iff (!rst_ni)
    drain_done |=> held_q == '0)
    else $error("buffer not emptied after drain");

endmodule

`default_nettype wire

>>> hw/rtl/rqnt_ram.sv
// ----------------------------------------------------------------------------
// rqnt_ram
// Generic single-write, single-read RAM with registered read data.
// ----------------------------------------------------------------------------
`default_nettype none

module rqnt_ram #(
  parameter int unsigned WIDTH = 32,
  parameter int unsigned DEPTH = 64
) (
  input  wire logic                                   clk_i,
  input  wire logic                                   we_i,
  input  wire logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr_i,
  input  wire logic [WIDTH-1:0]                       wdata_i,
  input  wire logic                                   re_i,
  input  wire logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr_i,
  output      logic [WIDTH-1:0]                       rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

`default_nettype wire

>>> hw/rtl/rqnt_lane.sv
// ----------------------------------------------------------------------------
// rqnt_lane
// One quantizer lane: magnitude times Q8.40 ratio in two 32x24 products,
// then round half away from zero, clamp to 127 and apply sign and offset.
// ----------------------------------------------------------------------------
`default_nettype none

module rqnt_lane (
  input  wire logic                                clk_i,
  input  wire logic signed [rqnt_pkg::VAL_W-1:0]   value_i,
  input  wire rqnt_pkg::lane_ctl_t                 ctl_i,
  input  wire logic [rqnt_pkg::RATIO_W-1:0]        ratio_i,
  output      logic [rqnt_pkg::ABS_W-1:0]          abs_o,
  output      logic [rqnt_pkg::BYTE_W-1:0]         byte_o
);

  logic [31:0] raw;
  logic        neg;
  logic [31:0] mag;

  logic [55:0] p_hi_d, p_hi_q;
  logic [55:0] p_lo_d, p_lo_q;
  logic        neg_q, en_q, uns_q;

  logic [56:0] t_sum;
  logic [56:0] t_rnd;
  logic [40:0] rnd;
  logic [7:0]  mag8;
  logic [7:0]  q_signed;
  logic [7:0]  q_out;
  logic [7:0]  byte_d, byte_q;

  // Magnitude; the most negative value keeps its exact 2^31
  assign raw = value_i;
  assign neg = raw[31];
  assign mag = neg ? (32'd0 - raw) : raw;

  // Saturated magnitude for max tracking, zero on invalid lanes
  assign abs_o = !ctl_i.lane_en ? '0 : (mag[31] ? '1 : mag[30:0]);

  // Stage 1: partial products
  assign p_hi_d = 56'(mag) * 56'(ratio_i[47:24]);
  assign p_lo_d = 56'(mag) * 56'(ratio_i[23:0]);

  always_ff @(posedge clk_i) begin
    p_hi_q <= p_hi_d;
    p_lo_q <= p_lo_d;
    neg_q  <= neg;
    en_q   <= ctl_i.lane_en;
    uns_q  <= ctl_i.unsigned_out;
  end

  // Stage 2: combine, round, clamp, sign, offset
  always_comb begin
    t_sum    = 57'(p_hi_q) + 57'(p_lo_q[55:24]);
    t_rnd    = t_sum + 57'd32768;
    rnd      = t_rnd[56:16];
    mag8     = (|rnd[40:7]) ? 8'd127 : {1'b0, rnd[6:0]};
    q_signed = neg_q ? (8'd0 - mag8) : mag8;
    q_out    = uns_q ? (q_signed + 8'd128) : q_signed;
    byte_d   = en_q ? q_out : 8'd0;
  end

  always_ff @(posedge clk_i) begin
    byte_q <= byte_d;
  end

  assign byte_o = byte_q;

endmodule

`default_nettype wire

>>> hw/rtl/rqnt_maxmerge.sv
// ----------------------------------------------------------------------------
// rqnt_maxmerge
// Merge stage: registers the lane magnitudes and folds them into the
// running maximum through a compare tree.
// ----------------------------------------------------------------------------
`default_nettype none

module rqnt_maxmerge (
  input  wire logic                                               clk_i,
  input  wire logic                                               rst_ni,
  input  wire logic                                               valid_i,
  input  wire logic [rqnt_pkg::LANES-1:0][rqnt_pkg::ABS_W-1:0]    abs_i,
  input  wire logic [rqnt_pkg::ABS_W-1:0]                         running_i,
  output      logic                                               fold_o,
  output      logic [rqnt_pkg::ABS_W-1:0]                         max_o
);

  logic                                             v_q;
  logic [rqnt_pkg::LANES-1:0][rqnt_pkg::ABS_W-1:0]  abs_q;
  logic [3:0][rqnt_pkg::ABS_W-1:0]                  lvl1;
  logic [1:0][rqnt_pkg::ABS_W-1:0]                  lvl2;
  logic [rqnt_pkg::ABS_W-1:0]                       lvl3;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v_q <= 1'b0;
    end else begin
      v_q <= valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    abs_q <= abs_i;
  end

  // Pairwise compare tree
  always_comb begin
    for (int i = 0; i < 4; i++) begin
      lvl1[i] = (abs_q[2*i] > abs_q[2*i+1]) ? abs_q[2*i] : abs_q[2*i+1];
    end
    for (int i = 0; i < 2; i++) begin
      lvl2[i] = (lvl1[2*i] > lvl1[2*i+1]) ? lvl1[2*i] : lvl1[2*i+1];
    end
    lvl3 = (lvl2[0] > lvl2[1]) ? lvl2[0] : lvl2[1];
  end

  assign fold_o = v_q;
  assign max_o  = (lvl3 > running_i) ? lvl3 : running_i;

endmodule

`default_nettype wire

>>> hw/rtl/rqnt_div.sv
// ----------------------------------------------------------------------------
// rqnt_div
// Restoring divider, one quotient bit per cycle, for the dynamic ratio.
// ----------------------------------------------------------------------------
`default_nettype none

module rqnt_div (
  input  wire logic                              clk_i,
  input  wire logic                              rst_ni,
  input  wire logic                              start_i,
  input  wire logic [rqnt_pkg::RATIO_W-1:0]      dividend_i,
  input  wire logic [rqnt_pkg::ABS_W-1:0]        divisor_i,
  output      logic                              done_o,
  output      logic [rqnt_pkg::RATIO_W-1:0]      quot_o
);

  localparam logic [5:0] STEPS = 6'(rqnt_pkg::RATIO_W);

  logic                               busy_q;
  logic                               done_q;
  logic [5:0]                         cnt_q;
  logic [rqnt_pkg::ABS_W-1:0]         rem_q;
  logic [rqnt_pkg::ABS_W-1:0]         dvs_q;
  logic [rqnt_pkg::RATIO_W-1:0]       quo_q;

  logic [rqnt_pkg::ABS_W:0]           rem_sh;
  logic [rqnt_pkg::ABS_W:0]           rem_sub;
  logic                               ge;

  // One shift-subtract step
  always_comb begin
    rem_sh  = {rem_q, quo_q[rqnt_pkg::RATIO_W-1]};
    ge      = rem_sh >= {1'b0, dvs_q};
    rem_sub = rem_sh - {1'b0, dvs_q};
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      done_q <= 1'b0;
      if (start_i) begin
        busy_q <= 1'b1;
        cnt_q  <= STEPS;
      end else if (busy_q) begin
        cnt_q <= cnt_q - 6'd1;
        if (cnt_q == 6'd1) begin
          busy_q <= 1'b0;
          done_q <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (start_i) begin
      quo_q <= dividend_i;
      rem_q <= '0;
      dvs_q <= divisor_i;
    end else if (busy_q) begin
      quo_q <= {quo_q[rqnt_pkg::RATIO_W-2:0], ge};
      rem_q <= ge ? rem_sub[rqnt_pkg::ABS_W-1:0] : rem_sh[rqnt_pkg::ABS_W-1:0];
    end
  end

  assign done_o = done_q;
  assign quot_o = quo_q;

endmodule

`default_nettype wire

>>> tb/sv/int32_to_int8_requantizer_top_tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// int32_to_int8_requantizer_top_tb
// Drives accumulator groups through the requantizer in fixed and dynamic
// mode, predicts every result beat and compares it field by field.
// ----------------------------------------------------------------------------
`default_nettype none

module int32_to_int8_requantizer_top_tb;

  localparam int unsigned LANES   = rqnt_pkg::LANES;
  localparam int unsigned VAL_W   = rqnt_pkg::VAL_W;
  localparam int unsigned CNT_W   = rqnt_pkg::CNT_W;
  localparam int unsigned RATIO_W = rqnt_pkg::RATIO_W;
  localparam int unsigned ABS_W   = rqnt_pkg::ABS_W;

  localparam int unsigned GROUPS    = 64;
  localparam int unsigned WDOG_MAX  = 5000;
  localparam int unsigned DRAIN_LAT = 80;

  logic                clk_i = 1'b0;
  logic                rst_ni = 1'b0;
  logic                in_valid_i = 1'b0;
  logic                in_stall_o;
  rqnt_pkg::in_beat_t  in_beat_i = '0;
  logic                out_valid_o;
  logic                out_stall_i = 1'b0;
  rqnt_pkg::out_beat_t out_beat_o;
  logic                cfg_we_i = 1'b0;
  logic [1:0]          cfg_idx_i = '0;
  logic [RATIO_W-1:0]  cfg_wdata_i = '0;

  int32_to_int8_requantizer_top #(.BUFFER_GROUPS(GROUPS)) dut (
    .clk_i, .rst_ni, .in_valid_i, .in_stall_o, .in_beat_i,
    .out_valid_o, .out_stall_i, .out_beat_o,
    .cfg_we_i, .cfg_idx_i, .cfg_wdata_i
  );

  always begin
    #4 clk_i = 1'b1;
    #4 clk_i = 1'b0;
  end

  // Predictor state
  logic               mode_dyn;
  logic [RATIO_W-1:0] ratio_fixed;
  logic               out_unsigned;
  logic [VAL_W-1:0]   held_vals [GROUPS][LANES];
  logic [CNT_W-1:0]   held_cnt  [GROUPS];
  int unsigned        held_n;
  logic [ABS_W-1:0]   max_abs;

  rqnt_pkg::out_beat_t expected_beats[$];
  int unsigned errors = 0;
  int unsigned beats_seen = 0;
  int unsigned groups_sent = 0;
  int unsigned wdog = 0;

  // Idling controls (percent)
  int unsigned send_idle_pct = 0;
  int unsigned recv_idle_pct = 0;
  bit          recv_hold = 1'b0;

  function automatic logic [VAL_W-1:0] lane_of(rqnt_pkg::in_beat_t b, int i);
    logic [LANES*VAL_W-1:0] flat;
    flat = b[$bits(rqnt_pkg::in_beat_t)-1 -: LANES*VAL_W];
    return flat[(LANES-1-i)*VAL_W +: VAL_W];
  endfunction

  function automatic logic [7:0] quant_byte(logic [VAL_W-1:0] raw, logic [RATIO_W-1:0] r);
    logic        neg;
    logic [32:0] mag;
    logic [81:0] prod;
    logic [81:0] rnd;
    logic [7:0]  q;
    neg  = raw[31];
    mag  = neg ? (33'h1_0000_0000 - {1'b0, raw}) : {1'b0, raw};
    prod = mag * r;
    rnd  = (prod + (82'd1 << 39)) >> 40;
    q    = (rnd > 127) ? 8'd127 : rnd[7:0];
    if (neg) q = 8'd0 - q;
    if (out_unsigned) q = q + 8'd128;
    return q;
  endfunction

  function automatic rqnt_pkg::out_beat_t make_result(logic [VAL_W-1:0] v[LANES],
                                                      logic [CNT_W-1:0] c,
                                                      logic [RATIO_W-1:0] r, logic last);
    rqnt_pkg::out_beat_t o;
    logic [LANES*8-1:0] bytes;
    bytes = '0;
    for (int i = 0; i < LANES; i++)
      if (i < c) bytes[(LANES-1-i)*8 +: 8] = quant_byte(v[i], r);
    o = {bytes, c, last, r};
    return o;
  endfunction

  // Predict result beats caused by one accepted group
  task automatic predict_group(rqnt_pkg::in_beat_t b);
    logic [VAL_W-1:0]   v [LANES];
    logic [CNT_W-1:0]   c;
    logic [VAL_W-1:0]   a;
    logic [RATIO_W-1:0] r;
    logic [95:0]        num;
    c = (b.valid_lanes > LANES) ? CNT_W'(LANES) : b.valid_lanes;
    for (int i = 0; i < LANES; i++) v[i] = lane_of(b, i);
    if (!mode_dyn) begin
      expected_beats.push_back(make_result(v, c, ratio_fixed, b.tensor_end));
      return;
    end
    if (held_n < GROUPS) begin
      for (int i = 0; i < c; i++) begin
        a = v[i][31] ? (32'd0 - v[i]) : v[i];
        if (a > 32'h7FFF_FFFF) a = 32'h7FFF_FFFF;
        if (a[30:0] > max_abs) max_abs = a[30:0];
      end
      for (int i = 0; i < LANES; i++) held_vals[held_n][i] = v[i];
      held_cnt[held_n] = c;
      held_n++;
    end
    if (!b.tensor_end) return;
    if (max_abs == 0) r = rqnt_pkg::RATIO_ONE;
    else begin
      num = ((96'd127 << 40) + (max_abs >> 1)) / max_abs;
      r = num[RATIO_W-1:0];
    end
    for (int g = 0; g < held_n; g++)
      expected_beats.push_back(make_result(held_vals[g], held_cnt[g], r, g + 1 == held_n));
    held_n = 0;
    max_abs = '0;
  endtask

  // Result checker
  always @(posedge clk_i) begin
    if (rst_ni && out_valid_o && !out_stall_i) begin
      beats_seen++;
      if (expected_beats.size() == 0) begin
        $display("%0t: unexpected beat, expected none, actual %h", $time, out_beat_o);
        errors++;
      end else begin
        rqnt_pkg::out_beat_t e;
        e = expected_beats.pop_front();
        if (e.lane0_byte !== out_beat_o.lane0_byte || e.lane1_byte !== out_beat_o.lane1_byte ||
            e.lane2_byte !== out_beat_o.lane2_byte || e.lane3_byte !== out_beat_o.lane3_byte ||
            e.lane4_byte !== out_beat_o.lane4_byte || e.lane5_byte !== out_beat_o.lane5_byte ||
            e.lane6_byte !== out_beat_o.lane6_byte || e.lane7_byte !== out_beat_o.lane7_byte) begin
          $display("%0t: lane bytes expected %h actual %h", $time,
                   e[$bits(rqnt_pkg::out_beat_t)-1 -: 64],
                   out_beat_o[$bits(rqnt_pkg::out_beat_t)-1 -: 64]);
          errors++;
        end
        if (e.out_valid_lanes !== out_beat_o.out_valid_lanes) begin
          $display("%0t: out_valid_lanes expected %0d actual %0d", $time,
                   e.out_valid_lanes, out_beat_o.out_valid_lanes);
          errors++;
        end
        if (e.run_end !== out_beat_o.run_end) begin
          $display("%0t: run_end expected %0d actual %0d", $time, e.run_end, out_beat_o.run_end);
          errors++;
        end
        if (e.ratio_used !== out_beat_o.ratio_used) begin
          $display("%0t: ratio_used expected %h actual %h", $time,
                   e.ratio_used, out_beat_o.ratio_used);
          errors++;
        end
      end
    end
  end

  // Receiver stall
  always @(posedge clk_i) begin
    out_stall_i <= recv_hold || ($urandom_range(99) < recv_idle_pct);
  end

  // Watchdog on accepted beats
  always @(posedge clk_i) begin
    if ((in_valid_i && !in_stall_o) || (out_valid_o && !out_stall_i)) wdog <= 0;
    else wdog <= wdog + 1;
    if (wdog >= WDOG_MAX) begin
      $display("Mismatches found");
      $finish;
    end
  end

  // Register write; waits until every pending result has left the block
  task automatic write_reg(rqnt_pkg::cfg_idx_e idx, logic [RATIO_W-1:0] val);
    in_valid_i <= 1'b0;
    while (expected_beats.size() != 0) @(posedge clk_i);
    @(posedge clk_i);
    cfg_we_i    <= 1'b1;
    cfg_idx_i   <= idx;
    cfg_wdata_i <= val;
    @(posedge clk_i);
    cfg_we_i    <= 1'b0;
    case (idx)
      rqnt_pkg::CFG_DYNAMIC_MODE:    mode_dyn     = val[0];
      rqnt_pkg::CFG_FIXED_RATIO:     ratio_fixed  = val;
      rqnt_pkg::CFG_UNSIGNED_OUTPUT: out_unsigned = val[0];
      default: ;
    endcase
  endtask

  task automatic wait_idle();
    in_valid_i <= 1'b0;
    while (expected_beats.size() != 0) @(posedge clk_i);
    repeat (DRAIN_LAT) @(posedge clk_i);
  endtask

  // Send one group; optional idle gap first
  task automatic send_group(rqnt_pkg::in_beat_t b);
    while ($urandom_range(99) < send_idle_pct) begin
      in_valid_i <= 1'b0;
      @(posedge clk_i);
    end
    in_valid_i <= 1'b1;
    in_beat_i  <= b;
    @(posedge clk_i);
    while (in_stall_o) @(posedge clk_i);
    predict_group(b);
    groups_sent++;
  endtask

  function automatic logic [VAL_W-1:0] rand_value();
    case ($urandom_range(5))
      0: return 32'h8000_0000;
      1: return 32'h7FFF_FFFF;
      2: return 32'(int'($urandom_range(600)) - 300);
      3: return 32'h0;
      default: return $urandom();
    endcase
  endfunction

  function automatic rqnt_pkg::in_beat_t rand_group(logic last);
    rqnt_pkg::in_beat_t b;
    logic [LANES*VAL_W-1:0] flat;
    for (int i = 0; i < LANES; i++) flat[i*VAL_W +: VAL_W] = rand_value();
    b = {flat, CNT_W'(($urandom_range(9) == 0) ? $urandom_range(15) : $urandom_range(1, 8)),
         last};
    return b;
  endfunction

  function automatic rqnt_pkg::in_beat_t fill_group(logic [VAL_W-1:0] v,
                                                    logic [CNT_W-1:0] c, logic last);
    rqnt_pkg::in_beat_t b;
    b = {{LANES{v}}, c, last};
    return b;
  endfunction

  task automatic test_fixed_directed();
    write_reg(rqnt_pkg::CFG_DYNAMIC_MODE, 48'd0);
    write_reg(rqnt_pkg::CFG_FIXED_RATIO, rqnt_pkg::RATIO_ONE);
    send_group(fill_group(32'h8000_0000, 4'd8, 1'b0));
    send_group(fill_group(32'h7FFF_FFFF, 4'd8, 1'b1));
    send_group(fill_group(32'd100, 4'd15, 1'b0));
    send_group(fill_group(32'hFFFF_FF9C, 4'd0, 1'b0));
    write_reg(rqnt_pkg::CFG_FIXED_RATIO, 48'd0);
    send_group(fill_group(32'h7FFF_FFFF, 4'd8, 1'b0));
    write_reg(rqnt_pkg::CFG_FIXED_RATIO, 48'hFFFF_FFFF_FFFF);
    send_group(fill_group(32'd1, 4'd3, 1'b0));
    write_reg(rqnt_pkg::CFG_FIXED_RATIO, 48'h00_8000_0000_00);
    send_group(fill_group(32'd3, 4'd8, 1'b0));
    send_group(fill_group(32'hFFFF_FFFD, 4'd8, 1'b0));
    write_reg(rqnt_pkg::CFG_UNSIGNED_OUTPUT, 48'd1);
    send_group(fill_group(32'hFFFF_FFFD, 4'd8, 1'b1));
    wait_idle();
  endtask

  task automatic test_dynamic_directed();
    write_reg(rqnt_pkg::CFG_DYNAMIC_MODE, 48'd1);
    write_reg(rqnt_pkg::CFG_UNSIGNED_OUTPUT, 48'd0);
    // all zero tensor gives ratio one
    send_group(fill_group(32'd0, 4'd8, 1'b1));
    // most negative value sets the max
    send_group(fill_group(32'h8000_0000, 4'd2, 1'b0));
    send_group(fill_group(32'd12345, 4'd0, 1'b0));
    send_group(fill_group(32'd77, 4'd12, 1'b1));
    wait_idle();
    // overfill the buffer; extra groups are dropped
    for (int g = 0; g < GROUPS + 2; g++) send_group(rand_group(g == GROUPS + 1));
    wait_idle();
  endtask

  task automatic test_random(int unsigned n);
    for (int i = 0; i < n; i++) begin
      if (mode_dyn) send_group(rand_group($urandom_range(7) == 0));
      else send_group(rand_group(1'($urandom_range(1))));
    end
    if (mode_dyn) send_group(rand_group(1'b1));
    wait_idle();
  endtask

  task automatic test_backpressure();
    write_reg(rqnt_pkg::CFG_DYNAMIC_MODE, 48'd0);
    write_reg(rqnt_pkg::CFG_FIXED_RATIO, 48'h00_0000_0100_00);
    send_idle_pct = 0;
    recv_hold = 1'b1;
    fork
      begin
        repeat (200) @(posedge clk_i);
        recv_hold = 1'b0;
      end
      for (int i = 0; i < 30; i++) send_group(rand_group(1'b0));
    join
    wait_idle();
  endtask

  initial begin
    mode_dyn = 0; ratio_fixed = '0; out_unsigned = 0; held_n = 0; max_abs = '0;
    repeat (7) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);
    send_idle_pct = 30; recv_idle_pct = 67;
    test_fixed_directed();
    test_dynamic_directed();
    test_random(35);
    write_reg(rqnt_pkg::CFG_DYNAMIC_MODE, 48'd0);
    write_reg(rqnt_pkg::CFG_FIXED_RATIO, {16'h0, $urandom()});
    test_random(35);
    send_idle_pct = 67; recv_idle_pct = 30;
    write_reg(rqnt_pkg::CFG_UNSIGNED_OUTPUT, 48'd1);
    test_random(35);
    write_reg(rqnt_pkg::CFG_DYNAMIC_MODE, 48'd1);
    test_random(35);
    send_idle_pct = 0; recv_idle_pct = 0;
    write_reg(rqnt_pkg::CFG_UNSIGNED_OUTPUT, 48'd0);
    test_random(30);
    test_backpressure();
    $display("Sent %0d groups, checked %0d result beats across fixed and dynamic modes,",
             groups_sent, beats_seen);
    $display("signed and unsigned output, buffer overflow and output back-pressure.");
    if (errors == 0) $display("No mismatches found");
    else $display("Mismatches found");
    $finish;
  end

endmodule

`default_nettype wire
